FILE: hdl/md4_pkg.sv
// ----------------------------------------------------------------------------
// md4_pkg
// shared types and constants for the md4 digest block
// ----------------------------------------------------------------------------
`default_nettype none

package md4_pkg;

  localparam logic [31:0] InitA = 32'h67452301;
  localparam logic [31:0] InitB = 32'hefcdab89;
  localparam logic [31:0] InitC = 32'h98badcfe;
  localparam logic [31:0] InitD = 32'h10325476;
  localparam logic [31:0] K2    = 32'h5A827999;
  localparam logic [31:0] K3    = 32'h6ED9EBA1;
  localparam logic [7:0]  PadMark = 8'h80;

  // request from front to back: one 64-byte block ready, last one of message
  typedef struct packed {
    logic       last;
  } blk_req_t;

  // message word index for round and step
  function automatic logic [3:0] word_idx(input logic [1:0] rnd, input logic [3:0] st);
    logic [3:0] r;
    begin
      unique case (rnd)
        2'd0: r = st;
        2'd1: r = {st[1:0], st[3:2]};
        default: r = {st[0], st[1], st[2], st[3]};
      endcase
      return r;
    end
  endfunction

  function automatic logic [4:0] shift_of(input logic [1:0] rnd, input logic [1:0] s);
    logic [4:0] r;
    begin
      unique case ({rnd, s})
        4'b0000: r = 5'd3;
        4'b0001: r = 5'd7;
        4'b0010: r = 5'd11;
        4'b0011: r = 5'd19;
        4'b0100: r = 5'd3;
        4'b0101: r = 5'd5;
        4'b0110: r = 5'd9;
        4'b0111: r = 5'd13;
        4'b1000: r = 5'd3;
        4'b1001: r = 5'd9;
        4'b1010: r = 5'd11;
        default: r = 5'd15;
      endcase
      return r;
    end
  endfunction

endpackage

`default_nettype wire

FILE: hdl/md4_front.sv
// ----------------------------------------------------------------------------
// md4_front
// gathers bytes into a block bank, appends padding, hands blocks to the back
// ----------------------------------------------------------------------------
`default_nettype none

module md4_front (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic [7:0]         byte_i,
  input  wire logic               has_data_i,
  input  wire logic               final_i,
  input  wire logic               valid_i,
  output logic                    ready_o,
  // block handoff, one block held at a time
  output logic                    blk_valid_o,
  input  wire logic               blk_ready_i,
  output md4_pkg::blk_req_t       blk_req_o,
  input  wire logic [3:0]         rd_addr_i,
  output logic [31:0]             rd_word_o
);
  import md4_pkg::*;

  typedef enum logic [1:0] {
    S_FILL, S_PAD, S_WAIT
  } state_e;

  logic [31:0] mem_q [16];       // little-endian words, byte writes
  logic [31:0] rd_word_q;
  state_e      state_q, state_d;
  logic [5:0]  fill_q, fill_d;
  logic [63:0] bits_q, bits_d;
  logic        fin_q, fin_d;     // pad marker still to be written
  logic        len_q, len_d;     // current or next pad block holds the length
  logic        bv_q, bv_d;
  logic        last_q, last_d;
  logic        we;
  logic [5:0]  wa;
  logic [7:0]  wd;
  logic        take;

  assign take = valid_i && ready_o;
  assign ready_o = (state_q == S_FILL) && !bv_q;
  assign blk_valid_o = bv_q;
  assign blk_req_o.last = last_q;
  assign rd_word_o = rd_word_q;

  always_comb begin
    state_d = state_q;
    fill_d = fill_q;
    bits_d = bits_q;
    fin_d = fin_q;
    len_d = len_q;
    bv_d = bv_q;
    last_d = last_q;
    we = 1'b0;
    wa = fill_q;
    wd = byte_i;
    if (bv_q && blk_ready_i) begin
      bv_d = 1'b0;
      if (last_q) begin
        bits_d = '0;
      end
    end
    unique case (state_q)
      S_FILL: begin
        if (take) begin
          if (has_data_i) begin
            we = 1'b1;
            bits_d = bits_q + 64'd8;
            fill_d = fill_q + 6'd1;
          end
          fin_d = final_i;
          if (has_data_i && fill_q == 6'd63) begin
            bv_d = 1'b1;
            last_d = 1'b0;
            state_d = S_WAIT;
          end else if (final_i) begin
            state_d = S_PAD;
          end
        end
      end
      S_PAD: begin
        // a pad write puts the marker while it is still owed, else zeros or length
        we = 1'b1;
        fill_d = fill_q + 6'd1;
        if (fin_q) begin
          wd = PadMark;
          fin_d = 1'b0;
          // length fits behind the marker only if it lands before byte 56
          len_d = (fill_q < 6'd56);
        end else if (fill_q >= 6'd56 && len_q) begin
          wd = bits_q[{fill_q[2:0], 3'b000} +: 8];
        end else begin
          wd = 8'h00;
        end
        if (fill_q == 6'd63) begin
          bv_d = 1'b1;
          state_d = S_WAIT;
          last_d = len_q && !fin_q;
          // no length in this block: the next pad block carries it
          len_d = !(len_q && !fin_q);
        end
      end
      default: begin
        if (bv_q && blk_ready_i) begin
          state_d = (fin_q || (!last_q && len_q)) ? S_PAD : S_FILL;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[wa[5:2]][{wa[1:0], 3'b000} +: 8] <= wd;
    end
    rd_word_q <= mem_q[rd_addr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_FILL;
      fill_q <= '0;
      bits_q <= '0;
      fin_q <= 1'b0;
      len_q <= 1'b0;
      bv_q <= 1'b0;
      last_q <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q <= fill_d;
      bits_q <= bits_d;
      fin_q <= fin_d;
      len_q <= len_d;
      bv_q <= bv_d;
      last_q <= last_d;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/md4_back.sv
// ----------------------------------------------------------------------------
// md4_back
// 48-step compression, one step a cycle, and four-word digest output
// ----------------------------------------------------------------------------
`default_nettype none

module md4_back (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               blk_valid_i,
  output logic                    blk_ready_o,
  input  wire md4_pkg::blk_req_t  blk_req_i,
  output logic [3:0]              rd_addr_o,
  input  wire logic [31:0]        rd_word_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [31:0]             out_word_o,
  output logic [1:0]              out_num_o,
  output logic                    out_last_o
);
  import md4_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE, S_RUN, S_EMIT
  } state_e;

  state_e      state_q;
  logic [31:0] ch_q [4];
  logic [31:0] r_q [4];
  logic [31:0] w_q [16];   // block copy, taken while running round one
  logic [5:0]  cnt_q;      // 0..48, word fetch addresses the word of the next step
  logic        last_q;
  logic [1:0]  num_q;
  logic [1:0]  rnd;
  logic [3:0]  st;
  logic [1:0]  t;
  logic [31:0] x, y, z, fv, kc, wv, sum, rot;
  logic [4:0]  sh;

  assign rnd = cnt_q[5:4] - 2'd0;
  assign st = cnt_q[3:0];
  assign t = 2'd0 - st[1:0];
  assign blk_ready_o = (state_q == S_IDLE);
  assign rd_addr_o = (state_q == S_RUN) ? (cnt_q[3:0] + 4'd1) : 4'd0;
  assign out_valid_o = (state_q == S_EMIT);
  assign out_word_o = ch_q[num_q];
  assign out_num_o = num_q;
  assign out_last_o = (num_q == 2'd3);

  always_comb begin
    x = r_q[t + 2'd1];
    y = r_q[t + 2'd2];
    z = r_q[t + 2'd3];
    wv = (rnd == 2'd0) ? rd_word_i : w_q[word_idx(rnd, st)];
    unique case (rnd)
      2'd0: begin fv = (x & y) | (~x & z); kc = '0; end
      2'd1: begin fv = (x & y) | (x & z) | (y & z); kc = K2; end
      default: begin fv = x ^ y ^ z; kc = K3; end
    endcase
    sum = r_q[t] + fv + wv + kc;
    sh = shift_of(rnd, st[1:0]);
    rot = (sum << sh) | (sum >> (6'd32 - {1'b0, sh}));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q <= '0;
      num_q <= '0;
      last_q <= 1'b0;
      ch_q[0] <= InitA;
      ch_q[1] <= InitB;
      ch_q[2] <= InitC;
      ch_q[3] <= InitD;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (blk_valid_i) begin
            // rd_addr 0 fetched this cycle, usable next
            last_q <= blk_req_i.last;
            cnt_q <= '0;
            state_q <= S_RUN;
          end
        end
        S_RUN: begin
          if (cnt_q == 6'd47) begin
            if (last_q) begin
              state_q <= S_EMIT;
              num_q <= '0;
            end else begin
              state_q <= S_IDLE;
            end
            for (int i = 0; i < 4; i++) begin
              ch_q[i] <= ch_q[i] + ((2'(i) == t) ? rot : r_q[i]);
            end
          end
          cnt_q <= cnt_q + 6'd1;
        end
        default: begin
          if (out_ready_i) begin
            num_q <= num_q + 2'd1;
            if (num_q == 2'd3) begin
              state_q <= S_IDLE;
              ch_q[0] <= InitA;
              ch_q[1] <= InitB;
              ch_q[2] <= InitC;
              ch_q[3] <= InitD;
            end
          end
        end
      endcase
    end
  end

  // working registers: loaded on start, one step per run cycle
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE) begin
      for (int i = 0; i < 4; i++) r_q[i] <= ch_q[i];
    end else if (state_q == S_RUN) begin
      r_q[t] <= rot;
      if (rnd == 2'd0) w_q[st] <= rd_word_i;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/md4_message_digest_top.sv
// ----------------------------------------------------------------------------
// md4_message_digest_top
// md4 digest of a byte stream, four digest words per message
// ----------------------------------------------------------------------------
// usage:
//   slave side takes one request per accepted beat: s_axis_tdata carries the
//   message byte, tuser[0] has_data, tlast ends the message (tuser[0]=0 with
//   tlast=1 ends an empty message or ends after the last data beat)
//   master side gives four words A..D, word number in tuser, tlast on D
// throughput:
//   one byte per cycle while a block gathers; each full 64-byte block holds
//   s_axis_tready low for its handoff, and its 48-step compression overlaps
//   the gathering of the next block
// message end:
//   after tlast, padding writes one byte a cycle up to byte 63 of the block,
//   and a second pad block follows when the marker lands at byte 56 or later;
//   each block is handed off and compressed in 48 steps, then the four words
//   appear one per cycle while the master side takes them
// reset: chaining words to md4 initial values, fill and bit count to zero
// a stalled master side holds the words; the front keeps taking bytes until
// it holds a full or padded block, then drops s_axis_tready
// ----------------------------------------------------------------------------
`default_nettype none

module md4_message_digest_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // data_byte
  input  wire logic        s_axis_tuser,   // has_data
  input  wire logic        s_axis_tlast,   // final_byte
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // digest_word
  output logic [1:0]       m_axis_tuser,   // word_number
  output logic             m_axis_tlast    // last_word
);
  import md4_pkg::*;

  logic        blk_valid, blk_ready;
  blk_req_t    blk_req;
  logic [3:0]  rd_addr;
  logic [31:0] rd_word;

  md4_front u_front (
    .clk_i, .rst_ni,
    .byte_i(s_axis_tdata), .has_data_i(s_axis_tuser), .final_i(s_axis_tlast),
    .valid_i(s_axis_tvalid), .ready_o(s_axis_tready),
    .blk_valid_o(blk_valid), .blk_ready_i(blk_ready), .blk_req_o(blk_req),
    .rd_addr_i(rd_addr), .rd_word_o(rd_word)
  );

  md4_back u_back (
    .clk_i, .rst_ni,
    .blk_valid_i(blk_valid), .blk_ready_o(blk_ready), .blk_req_i(blk_req),
    .rd_addr_o(rd_addr), .rd_word_i(rd_word),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .out_word_o(m_axis_tdata), .out_num_o(m_axis_tuser), .out_last_o(m_axis_tlast)
  );

  // the last flag only on word D
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser == 2'd3)))
    else $error("last flag off word D");

  // digest word held while the master side stalls
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
    else $error("digest word changed while stalled");

  // word number steps only on a handshake
  a_num: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tuser)))
    else $error("word number moved without request");

endmodule

`default_nettype wire
